// ===== src/joint_clamp_slew_watchdog_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef JOINT_CLAMP_SLEW_WATCHDOG_UNIT_DEFINES_SVH
`define JOINT_CLAMP_SLEW_WATCHDOG_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JCSW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jcsw check failed");

// next-cycle implication, sampled on clk, off during reset
`define JCSW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jcsw check failed");

`endif

// ===== src/jcsw_pkg.sv =====
package jcsw_pkg;

	localparam int JOINTS = 7;
	localparam int JOINT_W = 16;
	localparam int LIMIT_W = 15;
	localparam int TIMEOUT_W = 16;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [LIMIT_W-1:0] POS_LIMIT_RST = 15'd4096;
	localparam logic [LIMIT_W-1:0] MAX_STEP_RST = 15'd328;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd200;

	localparam logic CMD_ACTION = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		REG_POS_LIMIT = 2'd0,
		REG_MAX_STEP = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	typedef logic signed [JOINT_W-1:0] joint_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] pos_limit;
		logic [LIMIT_W-1:0] max_step;
	} lane_cfg_t;

	typedef struct packed {
		logic tick;
		logic action;
	} wd_ctl_t;

	typedef struct packed {
		joint_t [JOINTS-1:0] joint;
		logic is_hold;
	} result_t;

endpackage

// ===== src/joint_clamp_slew_watchdog_unit.sv =====
// Joint clamp, slew limiter and idle watchdog. Each transfer on the req channel is
// either an action (cmd 0) carrying seven Q3.12 joint requests or a 1 ms tick
// (cmd 1). An action clamps each joint to +/- the position limit, limits its change
// from the last output to +/-max_step, stores and returns the result with is_hold 0,
// and rearms the watchdog. A tick advances a saturating idle counter; the first
// tick on which it exceeds timeout_ticks returns the stored outputs once with
// is_hold 1. The block takes one item per clock while req_ready is high: seven
// clamp lanes and the watchdog finish an item in the cycle it is accepted, and its
// result is written into a two-entry output buffer that drives the rsp channel.
// Under backpressure req_ready drops only while two results wait. Registers sit on an
// APB port at 0x0 position limit, 0x4 max_step, 0x8 timeout_ticks, readable.
module joint_clamp_slew_watchdog_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [jcsw_pkg::ADDR_W-1:0]      paddr,
	input  logic [jcsw_pkg::DATA_W-1:0]      pwdata,
	output logic [jcsw_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic                             cmd,
	input  jcsw_pkg::joint_t                 joint_in_0,
	input  jcsw_pkg::joint_t                 joint_in_1,
	input  jcsw_pkg::joint_t                 joint_in_2,
	input  jcsw_pkg::joint_t                 joint_in_3,
	input  jcsw_pkg::joint_t                 joint_in_4,
	input  jcsw_pkg::joint_t                 joint_in_5,
	input  jcsw_pkg::joint_t                 joint_in_6,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output jcsw_pkg::joint_t                 joint_out_0,
	output jcsw_pkg::joint_t                 joint_out_1,
	output jcsw_pkg::joint_t                 joint_out_2,
	output jcsw_pkg::joint_t                 joint_out_3,
	output jcsw_pkg::joint_t                 joint_out_4,
	output jcsw_pkg::joint_t                 joint_out_5,
	output jcsw_pkg::joint_t                 joint_out_6,
	output logic                             is_hold
);
	import jcsw_pkg::*;

	logic [LIMIT_W-1:0] pos_limit_q;
	logic [LIMIT_W-1:0] max_step_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic wr_en;
	reg_idx_t reg_idx;

	lane_cfg_t lane_cfg;
	wd_ctl_t wd_ctl;
	logic accept;
	logic hold;
	logic push;
	joint_t jin [JOINTS];
	joint_t prev_out [JOINTS];
	joint_t next_out [JOINTS];
	result_t push_data;
	result_t rsp_data;

	// config port
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_limit_q <= POS_LIMIT_RST;
			max_step_q <= MAX_STEP_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_POS_LIMIT: pos_limit_q <= pwdata[LIMIT_W-1:0];
				REG_MAX_STEP:  max_step_q <= pwdata[LIMIT_W-1:0];
				REG_TIMEOUT:   timeout_q <= pwdata[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POS_LIMIT: prdata = DATA_W'(pos_limit_q);
			REG_MAX_STEP:  prdata = DATA_W'(max_step_q);
			REG_TIMEOUT:   prdata = DATA_W'(timeout_q);
			default:       prdata = '0;
		endcase
	end

	// datapath
	assign accept = req_valid && req_ready;
	assign wd_ctl.action = accept && (cmd == CMD_ACTION);
	assign wd_ctl.tick = accept && (cmd == CMD_TICK);
	assign lane_cfg.pos_limit = pos_limit_q;
	assign lane_cfg.max_step = max_step_q;

	assign jin[0] = joint_in_0;
	assign jin[1] = joint_in_1;
	assign jin[2] = joint_in_2;
	assign jin[3] = joint_in_3;
	assign jin[4] = joint_in_4;
	assign jin[5] = joint_in_5;
	assign jin[6] = joint_in_6;

	for (genvar j = 0; j < JOINTS; j++) begin : g_lane
		jcsw_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.update   (wd_ctl.action),
			.cfg      (lane_cfg),
			.joint_req(jin[j]),
			.prev_out (prev_out[j]),
			.next_out (next_out[j])
		);
		assign push_data.joint[j] = wd_ctl.action ? next_out[j] : prev_out[j];
	end

	jcsw_watchdog u_watchdog (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wd_ctl),
		.timeout(timeout_q),
		.hold   (hold)
	);

	assign push_data.is_hold = !wd_ctl.action;
	assign push = wd_ctl.action || hold;

	jcsw_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.space    (req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	assign joint_out_0 = rsp_data.joint[0];
	assign joint_out_1 = rsp_data.joint[1];
	assign joint_out_2 = rsp_data.joint[2];
	assign joint_out_3 = rsp_data.joint[3];
	assign joint_out_4 = rsp_data.joint[4];
	assign joint_out_5 = rsp_data.joint[5];
	assign joint_out_6 = rsp_data.joint[6];
	assign is_hold = rsp_data.is_hold;

endmodule

// ===== src/jcsw_lane.sv =====
module jcsw_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               update,
	input  jcsw_pkg::lane_cfg_t cfg,
	input  jcsw_pkg::joint_t   joint_req,
	output jcsw_pkg::joint_t   prev_out,
	output jcsw_pkg::joint_t   next_out
);
	import jcsw_pkg::*;

	joint_t prev_q;
	logic signed [JOINT_W:0] req_x;
	logic signed [JOINT_W:0] pos_bound;
	logic signed [JOINT_W:0] pos;
	logic signed [JOINT_W+1:0] diff;
	logic signed [JOINT_W+1:0] step_bound;
	logic signed [JOINT_W+1:0] delta;

	// clamp to position bound
	always_comb begin
		req_x = {joint_req[JOINT_W-1], joint_req};
		pos_bound = $signed({2'b00, cfg.pos_limit});
		if (req_x > pos_bound) begin
			pos = pos_bound;
		end else if (req_x < -pos_bound) begin
			pos = -pos_bound;
		end else begin
			pos = req_x;
		end
	end

	// clamp change against the previous output
	always_comb begin
		diff = {pos[JOINT_W], pos} - {{2{prev_q[JOINT_W-1]}}, prev_q};
		step_bound = $signed({3'b000, cfg.max_step});
		if (diff > step_bound) begin
			delta = step_bound;
		end else if (diff < -step_bound) begin
			delta = -step_bound;
		end else begin
			delta = diff;
		end
		next_out = prev_q + delta[JOINT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (update) begin
			prev_q <= next_out;
		end
	end

	assign prev_out = prev_q;

endmodule

// ===== src/jcsw_watchdog.sv =====
module jcsw_watchdog (
	input  logic                               clk,
	input  logic                               arst_n,
	input  jcsw_pkg::wd_ctl_t                  ctl,
	input  logic [jcsw_pkg::TIMEOUT_W-1:0]     timeout,
	output logic                               hold
);
	import jcsw_pkg::*;

	logic [TIMEOUT_W-1:0] count_q;
	logic [TIMEOUT_W-1:0] count_inc;
	logic flag_q;

	assign count_inc = (count_q == {TIMEOUT_W{1'b1}}) ? count_q : count_q + 1'b1;
	assign hold = ctl.tick && (count_inc > timeout) && !flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q <= 1'b0;
		end else if (ctl.action) begin
			count_q <= '0;
			flag_q <= 1'b0;
		end else if (ctl.tick) begin
			count_q <= count_inc;
			if (hold) begin
				flag_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/jcsw_merge.sv =====
module jcsw_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jcsw_pkg::result_t   push_data,
	output logic                space,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output jcsw_pkg::result_t   rsp_data
);
	import jcsw_pkg::*;

	result_t buf_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic pop;

	assign rsp_valid = (cnt_q != 2'd0);
	assign space = (cnt_q != 2'd2);
	assign pop = rsp_valid && rsp_ready;
	assign rsp_data = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/jcsw_checker.sv =====
`include "joint_clamp_slew_watchdog_unit_defines.svh"

module jcsw_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic cmd,
	input logic rsp_valid,
	input logic rsp_ready
);
	import jcsw_pkg::*;

	`JCSW_ASSERT_NEXT(a_action_gives_rsp, req_valid && req_ready && (cmd == CMD_ACTION), rsp_valid)
	`JCSW_ASSERT_NOW(a_full_has_rsp, !req_ready, rsp_valid)
	`JCSW_ASSERT_NEXT(a_rsp_stall_holds, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind joint_clamp_slew_watchdog_unit jcsw_checker u_jcsw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.cmd      (cmd),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready)
);

// ===== test/tb_joint_clamp_slew_watchdog_unit.sv =====
`timescale 1ns / 1ps

module tb_joint_clamp_slew_watchdog_unit;
	import jcsw_pkg::*;

	typedef struct packed {
		logic cmd;
		joint_t [JOINTS-1:0] joint;
	} cmd_item_t;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	logic cmd = CMD_ACTION;
	joint_t joint_in_0 = '0;
	joint_t joint_in_1 = '0;
	joint_t joint_in_2 = '0;
	joint_t joint_in_3 = '0;
	joint_t joint_in_4 = '0;
	joint_t joint_in_5 = '0;
	joint_t joint_in_6 = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	joint_t joint_out_0;
	joint_t joint_out_1;
	joint_t joint_out_2;
	joint_t joint_out_3;
	joint_t joint_out_4;
	joint_t joint_out_5;
	joint_t joint_out_6;
	logic is_hold;

	joint_clamp_slew_watchdog_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.joint_in_0(joint_in_0),
		.joint_in_1(joint_in_1),
		.joint_in_2(joint_in_2),
		.joint_in_3(joint_in_3),
		.joint_in_4(joint_in_4),
		.joint_in_5(joint_in_5),
		.joint_in_6(joint_in_6),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.joint_out_0(joint_out_0),
		.joint_out_1(joint_out_1),
		.joint_out_2(joint_out_2),
		.joint_out_3(joint_out_3),
		.joint_out_4(joint_out_4),
		.joint_out_5(joint_out_5),
		.joint_out_6(joint_out_6),
		.is_hold(is_hold)
	);

	// limiter state as the testbench sees it
	logic [LIMIT_W-1:0] lim_cfg = POS_LIMIT_RST;
	logic [LIMIT_W-1:0] step_cfg = MAX_STEP_RST;
	logic [TIMEOUT_W-1:0] tmo_cfg = TIMEOUT_RST;
	joint_t held_out [JOINTS];
	logic [TIMEOUT_W-1:0] idle_ticks = '0;
	logic tripped = 1'b0;

	cmd_item_t cmd_backlog [$];
	result_t queued_outputs [$];
	logic req_fired = 1'b0;
	bit steady = 1'b0;
	int failures = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int clamp_sym(input int x, input int bound);
		if (x > bound)
			return bound;
		if (x < -bound)
			return -bound;
		return x;
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("mismatch: %s", msg);
	endtask

	// driver: hold until transfer, then present the next pending item
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && !req_fired)) begin
			if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 6)) begin
				cmd <= cmd_backlog[0].cmd;
				joint_in_0 <= cmd_backlog[0].joint[0];
				joint_in_1 <= cmd_backlog[0].joint[1];
				joint_in_2 <= cmd_backlog[0].joint[2];
				joint_in_3 <= cmd_backlog[0].joint[3];
				joint_in_4 <= cmd_backlog[0].joint[4];
				joint_in_5 <= cmd_backlog[0].joint[5];
				joint_in_6 <= cmd_backlog[0].joint[6];
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ready <= steady || ($urandom_range(0, 99) >= 6);
	end

	// monitor: predict on each req transfer, check each rsp transfer
	always @(posedge clk) begin : monitor
		cmd_item_t seen;
		result_t want;
		result_t got;
		int pos;
		int delta;
		req_fired = arst_n && req_valid && req_ready;
		if (req_fired) begin
			void'(cmd_backlog.pop_front());
			seen.cmd = cmd;
			seen.joint[0] = joint_in_0;
			seen.joint[1] = joint_in_1;
			seen.joint[2] = joint_in_2;
			seen.joint[3] = joint_in_3;
			seen.joint[4] = joint_in_4;
			seen.joint[5] = joint_in_5;
			seen.joint[6] = joint_in_6;
			if (seen.cmd == CMD_ACTION) begin
				for (int j = 0; j < JOINTS; j++) begin
					pos = clamp_sym($signed(seen.joint[j]), int'(lim_cfg));
					delta = clamp_sym(pos - held_out[j], int'(step_cfg));
					held_out[j] = joint_t'(held_out[j] + delta);
					want.joint[j] = held_out[j];
				end
				idle_ticks = '0;
				tripped = 1'b0;
				want.is_hold = 1'b0;
				queued_outputs.insert(queued_outputs.size(), want);
			end else begin
				if (idle_ticks != '1)
					idle_ticks++;
				if (idle_ticks > tmo_cfg && !tripped) begin
					tripped = 1'b1;
					for (int j = 0; j < JOINTS; j++)
						want.joint[j] = held_out[j];
					want.is_hold = 1'b1;
					queued_outputs.insert(queued_outputs.size(), want);
				end
			end
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			got.joint[0] = joint_out_0;
			got.joint[1] = joint_out_1;
			got.joint[2] = joint_out_2;
			got.joint[3] = joint_out_3;
			got.joint[4] = joint_out_4;
			got.joint[5] = joint_out_5;
			got.joint[6] = joint_out_6;
			got.is_hold = is_hold;
			if (queued_outputs.size() == 0) begin
				note_failure($sformatf("transfer with nothing expected, is_hold %0b",
					got.is_hold));
			end else begin
				want = queued_outputs.pop_front();
				for (int j = 0; j < JOINTS; j++) begin
					if (got.joint[j] !== want.joint[j])
						note_failure($sformatf("joint_out_%0d expected %0d got %0d", j,
							$signed(want.joint[j]), $signed(got.joint[j])));
				end
				if (got.is_hold !== want.is_hold)
					note_failure($sformatf("is_hold expected %0b got %0b",
						want.is_hold, got.is_hold));
			end
		end
	end

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || queued_outputs.size() != 0 || req_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POS_LIMIT: lim_cfg = value[LIMIT_W-1:0];
			REG_MAX_STEP: step_cfg = value[LIMIT_W-1:0];
			REG_TIMEOUT: tmo_cfg = value[TIMEOUT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_action(input joint_t [JOINTS-1:0] v);
		cmd_item_t it;
		it.cmd = CMD_ACTION;
		it.joint = v;
		cmd_backlog.insert(cmd_backlog.size(), it);
	endtask

	task automatic push_tick();
		cmd_item_t it;
		it.cmd = CMD_TICK;
		for (int j = 0; j < JOINTS; j++)
			it.joint[j] = joint_t'($urandom);
		cmd_backlog.insert(cmd_backlog.size(), it);
	endtask

	function automatic joint_t pick_joint(input int j);
		int sgn;
		sgn = ($urandom_range(0, 1) == 0) ? 1 : -1;
		case ($urandom_range(0, 3))
			0: return joint_t'($urandom);
			1: return joint_t'(sgn * int'(lim_cfg) + int'($urandom_range(0, 4)) - 2);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: return joint_t'(held_out[j] + sgn * (int'(step_cfg)
				+ int'($urandom_range(0, 6)) - 3));
		endcase
	endfunction

	task automatic push_random_action();
		joint_t [JOINTS-1:0] v;
		for (int j = 0; j < JOINTS; j++)
			v[j] = pick_joint(j);
		push_action(v);
	endtask

	task automatic random_phase(input int count);
		int burst;
		burst = 0;
		for (int n = 0; n < count; n++) begin
			if (burst > 0) begin
				push_tick();
				burst--;
			end else if ($urandom_range(0, 99) < 70) begin
				push_random_action();
			end else begin
				if ($urandom_range(0, 1) == 0 || tmo_cfg > 300)
					burst = $urandom_range(1, 4);
				else
					burst = int'(tmo_cfg) + int'($urandom_range(0, 3));
				push_tick();
				burst--;
			end
		end
	endtask

	initial begin
		int phase;
		int rand_items;
		for (int j = 0; j < JOINTS; j++)
			held_out[j] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// hold before any action, then no repeat
		write_reg(REG_TIMEOUT, 32'd0);
		push_tick();
		push_tick();
		write_reg(REG_TIMEOUT, 32'd3);
		push_action({JOINTS{16'sh7FFF}});
		push_action({JOINTS{16'sh8000}});
		push_action({16'shEFFF, 16'sh1001, 16'shF000, 16'sh1000, 16'sh0000,
			16'sh8000, 16'sh7FFF});
		push_action({JOINTS{16'sh0000}});
		repeat (5) push_tick();
		push_action({16'sh0001, 16'shFFFF, 16'sh0148, 16'shFEB8, 16'sh0149,
			16'shFEB7, 16'sh5555});
		repeat (2) push_tick();
		write_reg(REG_POS_LIMIT, 32'd0);
		write_reg(REG_MAX_STEP, 32'd32767);
		push_action({16'sh7FFF, 16'sh8000, 16'sh1234, 16'shAAAA, 16'sh0001,
			16'shFFFF, 16'sh4000});
		write_reg(REG_POS_LIMIT, 32'd32767);
		push_action({JOINTS{16'sh7FFF}});
		push_action({JOINTS{16'sh8000}});
		write_reg(REG_MAX_STEP, 32'd0);
		push_action({JOINTS{16'sh7FFF}});
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		push_action({JOINTS{16'sh0000}});
		push_tick();

		phase = 0;
		rand_items = 0;
		while (rand_items < 1540) begin
			case (phase)
				0: begin
					write_reg(REG_POS_LIMIT, 32'(POS_LIMIT_RST));
					write_reg(REG_MAX_STEP, 32'(MAX_STEP_RST));
					write_reg(REG_TIMEOUT, 32'(TIMEOUT_RST));
				end
				1: begin
					write_reg(REG_POS_LIMIT, 32'd32767);
					write_reg(REG_MAX_STEP, 32'd32767);
					write_reg(REG_TIMEOUT, 32'd0);
				end
				2: begin
					write_reg(REG_POS_LIMIT, 32'd0);
					write_reg(REG_MAX_STEP, $urandom_range(0, 32767));
					write_reg(REG_TIMEOUT, 32'd5);
				end
				3: begin
					write_reg(REG_POS_LIMIT, $urandom_range(0, 32767));
					write_reg(REG_MAX_STEP, 32'd0);
					write_reg(REG_TIMEOUT, $urandom_range(0, 20));
				end
				4: begin
					write_reg(REG_POS_LIMIT, $urandom_range(0, 32767));
					write_reg(REG_MAX_STEP, $urandom_range(0, 2000));
					write_reg(REG_TIMEOUT, 32'd65535);
				end
				default: begin
					write_reg(REG_POS_LIMIT, $urandom);
					write_reg(REG_MAX_STEP, ($urandom_range(0, 1) == 0) ?
						$urandom : $urandom_range(0, 1500));
					write_reg(REG_TIMEOUT, {16'($urandom_range(0, 65535)), 16'd0}
						| $urandom_range(0, 40));
				end
			endcase
			steady = (phase == 0);
			if (phase == 5) begin
				// stall the sender until the outputs catch up
				random_phase(110);
				wait_drained();
				random_phase(110);
			end else begin
				random_phase(220);
			end
			rand_items += 220;
			phase++;
		end

		wait_drained();
		repeat (5) @(negedge clk);
		failures += queued_outputs.size();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
